### rtl/core/light_bar_pair_scorer_macros.svh
// Assertion macros shared by the light bar pair scorer RTL.
`ifndef LIGHT_BAR_PAIR_SCORER_MACROS_SVH
`define LIGHT_BAR_PAIR_SCORER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LBPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbps assertion failed");

// Next-cycle implication, checked outside reset.
`define LBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbps assertion failed");

`endif

### rtl/core/lbps_pkg.sv
// Types, constants and helpers of the light bar pair scorer.
package lbps_pkg;

  localparam int unsigned ANG_W = 14;
  localparam int unsigned AD_W  = 13;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned IDX_W = 6;

  localparam logic [ANG_W-1:0] ANG_HALF    = 14'd11520;
  localparam logic [AD_W-1:0]  ANG_QUARTER = 13'd5760;

  localparam int unsigned FIFO_DEPTH = 2;

  // Squared distance and its root
  localparam int unsigned SQ_W   = 2 * LEN_W;
  localparam int unsigned D2_W   = SQ_W + 1;
  localparam int unsigned RAD_W  = 50;
  localparam int unsigned ROOT_W = RAD_W / 2;

  // Divider shapes
  localparam int unsigned SZ_N_W  = LEN_W + 8;
  localparam int unsigned SZ_Q_W  = 9;
  localparam int unsigned AR_Q_W  = 16;
  localparam int unsigned SC_Q_W  = 17;
  localparam int unsigned SC_N_W  = 25;
  localparam int unsigned SR_D_W  = 17;
  localparam int unsigned SA_D_W  = 13;
  localparam logic [SC_N_W-1:0] SR_NUM = 25'd16777216;
  localparam logic [SC_N_W-1:0] SA_NUM = 25'd20971520;
  localparam logic [SR_D_W-1:0] SR_BASE = 17'd256;
  localparam logic [SA_D_W-1:0] SA_BASE = 13'd320;

  // Confidence sum and divide by ten through a reciprocal
  localparam int unsigned SS_W     = 17;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned PROD_W   = 40;
  localparam int unsigned RECIP_SH = 23;
  localparam logic [SUM_W-1:0] RECIP_10 = 20'd838861;
  localparam logic [SUM_W-1:0] W_SIZE   = 20'd3;
  localparam logic [SUM_W-1:0] W_RATIO  = 20'd4;
  localparam logic [SUM_W-1:0] W_ANGLE  = 20'd3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [2:0] {
    RSN_PASS,
    RSN_ANGLE,
    RSN_SIZE,
    RSN_VERT,
    RSN_ASPECT,
    RSN_DEGEN
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ANGLE,
    CFG_MAX_HDIFF,
    CFG_MAX_WDIFF,
    CFG_VERT_FACTOR,
    CFG_MIN_ASPECT,
    CFG_MAX_ASPECT,
    CFG_IDEAL_ASPECT
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0] max_angle_diff;
    logic [8:0]  max_height_diff_ratio;
    logic [8:0]  max_width_diff_ratio;
    logic [11:0] vertical_offset_factor;
    logic [11:0] min_aspect_ratio;
    logic [11:0] max_aspect_ratio;
    logic [11:0] ideal_aspect_ratio;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{13'd1280, 9'd128, 9'd205, 12'd307,
                                 12'd256, 12'd1536, 12'd614};

  typedef struct packed {
    logic [ANG_W-1:0] angle_a;
    logic [LEN_W-1:0] width_a;
    logic [LEN_W-1:0] height_a;
    logic [LEN_W-1:0] center_x_a;
    logic [LEN_W-1:0] center_y_a;
    logic [ANG_W-1:0] angle_b;
    logic [LEN_W-1:0] width_b;
    logic [LEN_W-1:0] height_b;
    logic [LEN_W-1:0] center_x_b;
    logic [LEN_W-1:0] center_y_b;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
  } pair_t;

  // Classified pair, front to back
  typedef struct packed {
    logic [AD_W-1:0]  ad;
    logic [LEN_W-1:0] dx;
    logic [LEN_W-1:0] dy;
    logic [LEN_W-1:0] dh;
    logic [LEN_W-1:0] dw;
    logic [LEN_W-1:0] mh;
    logic [LEN_W-1:0] mw;
    logic             degen;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
  } item_t;

  typedef struct packed {
    logic [AD_W-1:0]  ad;
    logic [LEN_W-1:0] dh;
    logic [LEN_W-1:0] dw;
    logic [LEN_W-1:0] mh;
    logic [LEN_W-1:0] mw;
    logic             degen;
    logic             vfail;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
  } tag_t;

  typedef struct packed {
    logic [AD_W-1:0]   ad;
    logic [LEN_W-1:0]  mh;
    logic              degen;
    logic              vfail;
    logic              sat;
    logic [SZ_Q_W-1:0] hr;
    logic [SZ_Q_W-1:0] wr;
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
  } mid_t;

  typedef struct packed {
    logic [AD_W-1:0]  ad;
    logic [LEN_W-1:0] ar;
    reason_e          reason;
    logic [SS_W-1:0]  ss;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
  } late_t;

  typedef struct packed {
    logic             pair_ok;
    reason_e          reason;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
    logic [LEN_W-1:0] confidence;
    logic [LEN_W-1:0] aspect_ratio;
    logic [AD_W-1:0]  angle_diff;
  } res_t;

  function automatic logic [LEN_W-1:0] absdiff16(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

### rtl/core/lbps_front.sv
// Front stage: takes a pair word and classifies it into differences and maxima.
module lbps_front import lbps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  pair_t pair_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic             valid_q, valid_d;
  item_t            item_q, item_d;
  logic             load;
  logic [ANG_W-1:0] aa, ab, adiff;
  logic [LEN_W-1:0] mh, mw;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    // clamp out-of-range angles, then fold the difference into 0..90 deg
    aa    = (pair_i.angle_a > ANG_HALF) ? ANG_HALF : pair_i.angle_a;
    ab    = (pair_i.angle_b > ANG_HALF) ? ANG_HALF : pair_i.angle_b;
    adiff = (aa > ab) ? aa - ab : ab - aa;
    mh    = (pair_i.height_a > pair_i.height_b) ? pair_i.height_a : pair_i.height_b;
    mw    = (pair_i.width_a > pair_i.width_b) ? pair_i.width_a : pair_i.width_b;

    item_d.ad = (adiff > {1'b0, ANG_QUARTER}) ? AD_W'(ANG_HALF - adiff)
                                               : adiff[AD_W-1:0];
    item_d.dx    = absdiff16(pair_i.center_x_a, pair_i.center_x_b);
    item_d.dy    = absdiff16(pair_i.center_y_a, pair_i.center_y_b);
    item_d.dh    = absdiff16(pair_i.height_a, pair_i.height_b);
    item_d.dw    = absdiff16(pair_i.width_a, pair_i.width_b);
    item_d.mh    = mh;
    item_d.mw    = mw;
    item_d.degen = (mh == '0) || (mw == '0);
    // ties go to the second bar on the left
    if (pair_i.center_x_a < pair_i.center_x_b) begin
      item_d.left_idx  = pair_i.index_a;
      item_d.right_idx = pair_i.index_b;
    end else begin
      item_d.left_idx  = pair_i.index_b;
      item_d.right_idx = pair_i.index_a;
    end
  end

  always_comb begin
    valid_d = valid_q && !ready_i;
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/lbps_fifo.sv
// Short queue between the front stage and the arithmetic pipeline.
`include "light_bar_pair_scorer_macros.svh"
module lbps_fifo import lbps_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `LBPS_ASSERT_IMPL(a_no_overflow, push_i, cnt_q != CNT_W'(DEPTH))
  `LBPS_ASSERT_IMPL(a_no_underflow, pop_i, cnt_q != '0)

endmodule

### rtl/core/lbps_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module lbps_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 9
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o
);

  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [NW-1:0] rem_d [QW];
  logic [DW-1:0] dvs_q [QW];
  logic [DW-1:0] dvs_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];
  logic [NW-1:0] rin   [QW];
  logic [DW-1:0] din   [QW];
  logic [QW-1:0] qin   [QW];

  always_comb begin
    rin[0] = dividend_i;
    din[0] = divisor_i;
    qin[0] = '0;
    for (int s = 1; s < QW; s++) begin
      rin[s] = rem_q[s-1];
      din[s] = dvs_q[s-1];
      qin[s] = quo_q[s-1];
    end
  end

  always_comb begin
    logic [CW-1:0] r;
    logic [CW-1:0] t;
    for (int s = 0; s < QW; s++) begin
      r = CW'(rin[s]);
      t = CW'(din[s]) << (QW - 1 - s);
      dvs_d[s] = din[s];
      if (r >= t) begin
        rem_d[s] = NW'(r - t);
        quo_d[s] = qin[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_d[s] = rin[s];
        quo_d[s] = qin[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dvs_q <= dvs_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

### rtl/core/lbps_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module lbps_sqrt #(
  parameter int unsigned RW = 50
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RW-1:0]     radicand_i,
  output logic [RW/2-1:0]   root_o
);

  localparam int unsigned S     = RW / 2;
  localparam int unsigned REM_W = S + 3;

  logic [RW-1:0]    rad_q  [S];
  logic [RW-1:0]    rad_d  [S];
  logic [REM_W-1:0] rem_q  [S];
  logic [REM_W-1:0] rem_d  [S];
  logic [S-1:0]     root_q [S];
  logic [S-1:0]     root_d [S];
  logic [RW-1:0]    rad_in [S];
  logic [REM_W-1:0] rem_in [S];
  logic [S-1:0]     root_in[S];

  always_comb begin
    rad_in[0]  = radicand_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int s = 1; s < S; s++) begin
      rad_in[s]  = rad_q[s-1];
      rem_in[s]  = rem_q[s-1];
      root_in[s] = root_q[s-1];
    end
  end

  always_comb begin
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    for (int s = 0; s < S; s++) begin
      // bring down the next two radicand bits and try root*4+1
      sh        = {rem_in[s][REM_W-3:0], rad_in[s][RW-1:RW-2]};
      trial     = REM_W'({root_in[s], 2'b01});
      rad_d[s]  = rad_in[s] << 2;
      if (sh >= trial) begin
        rem_d[s]  = sh - trial;
        root_d[s] = {root_in[s][S-2:0], 1'b1};
      end else begin
        rem_d[s]  = sh;
        root_d[s] = {root_in[s][S-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q[S-1];

endmodule

### rtl/core/lbps_back.sv
// Arithmetic pipeline: ratios, tests, aspect ratio and confidence.
`include "light_bar_pair_scorer_macros.svh"
module lbps_back import lbps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  head_valid_i,
  input  item_t head_i,
  output logic  pop_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  res_o
);

  localparam int unsigned K_B0    = 1;
  localparam int unsigned K_SQ    = K_B0 + ROOT_W;
  localparam int unsigned K_SZ_IN = K_SQ - SZ_Q_W;
  localparam int unsigned K_AR    = K_SQ + AR_Q_W;
  localparam int unsigned K_ARR   = K_AR + 1;
  localparam int unsigned K_SC    = K_ARR + SC_Q_W;
  localparam int unsigned K_SUM   = K_SC + 1;
  localparam int unsigned K_PROD  = K_SUM + 1;
  localparam int unsigned K_OUT   = K_PROD + 1;
  localparam int unsigned SAT_W   = LEN_W + AR_Q_W;
  localparam int unsigned VF_W    = LEN_W + 12;
  localparam int unsigned Q10_W   = PROD_W - RECIP_SH;

  logic               en;
  logic [K_OUT:1]     v_q;
  tag_t               tag_d;
  tag_t               tag_q  [K_B0:K_SQ];
  logic [D2_W-1:0]    d2_d, d2_q;
  logic [ROOT_W-1:0]  dq;
  logic [SZ_Q_W-1:0]  hr, wr;
  mid_t               mid_d;
  mid_t               mid_q  [K_SQ+1:K_ARR];
  logic [AR_Q_W-1:0]  ar_quo;
  logic [LEN_W-1:0]   ar_d, ar_q;
  late_t              late_d;
  late_t              late_q [K_ARR+1:K_PROD];
  logic [SR_D_W-1:0]  sr_dvs;
  logic [SA_D_W-1:0]  sa_dvs;
  logic [SC_Q_W-1:0]  sr, sa;
  logic [SUM_W-1:0]   sum_d, sum_q;
  logic [PROD_W-1:0]  prod_d, prod_q;
  logic [Q10_W-1:0]   q10;
  res_t               res_d, res_q;

  // the whole pipeline moves together; it stops only for a held output word
  assign en    = !v_q[K_OUT] || ready_i;
  assign pop_o = en && head_valid_i;

  // first stage: squares and the vertical test
  always_comb begin
    tag_d.ad        = head_i.ad;
    tag_d.dh        = head_i.dh;
    tag_d.dw        = head_i.dw;
    tag_d.mh        = head_i.mh;
    tag_d.mw        = head_i.mw;
    tag_d.degen     = head_i.degen;
    tag_d.vfail     = VF_W'({head_i.dy, 8'b0}) >
                      VF_W'(head_i.mh) * VF_W'(cfg_i.vertical_offset_factor);
    tag_d.left_idx  = head_i.left_idx;
    tag_d.right_idx = head_i.right_idx;
    d2_d = D2_W'(SQ_W'(head_i.dx) * SQ_W'(head_i.dx)) +
           D2_W'(SQ_W'(head_i.dy) * SQ_W'(head_i.dy));
  end

  lbps_sqrt #(.RW(RAD_W)) u_sqrt (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (RAD_W'({d2_q, 16'b0})),
    .root_o     (dq)
  );

  lbps_div #(.NW(SZ_N_W), .DW(LEN_W), .QW(SZ_Q_W)) u_div_hr (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({tag_q[K_SZ_IN].dh, 8'b0}),
    .divisor_i  (tag_q[K_SZ_IN].mh),
    .quotient_o (hr)
  );

  lbps_div #(.NW(SZ_N_W), .DW(LEN_W), .QW(SZ_Q_W)) u_div_wr (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({tag_q[K_SZ_IN].dw, 8'b0}),
    .divisor_i  (tag_q[K_SZ_IN].mw),
    .quotient_o (wr)
  );

  lbps_div #(.NW(ROOT_W), .DW(LEN_W), .QW(AR_Q_W)) u_div_ar (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dq),
    .divisor_i  (tag_q[K_SQ].mh),
    .quotient_o (ar_quo)
  );

  always_comb begin
    mid_d.ad        = tag_q[K_SQ].ad;
    mid_d.mh        = tag_q[K_SQ].mh;
    mid_d.degen     = tag_q[K_SQ].degen;
    mid_d.vfail     = tag_q[K_SQ].vfail;
    // quotient would not fit in 16 bits: saturate
    mid_d.sat       = SAT_W'(dq) >= {tag_q[K_SQ].mh, {AR_Q_W{1'b0}}};
    mid_d.hr        = hr;
    mid_d.wr        = wr;
    mid_d.left_idx  = tag_q[K_SQ].left_idx;
    mid_d.right_idx = tag_q[K_SQ].right_idx;
  end

  always_comb begin
    ar_d = ar_quo;
    if (mid_q[K_AR].mh == '0) begin
      ar_d = '0;
    end else if (mid_q[K_AR].sat) begin
      ar_d = '1;
    end
  end

  // tests in order, first failure wins
  always_comb begin
    late_d.ad        = mid_q[K_ARR].ad;
    late_d.ar        = ar_q;
    late_d.left_idx  = mid_q[K_ARR].left_idx;
    late_d.right_idx = mid_q[K_ARR].right_idx;
    late_d.ss        = SS_W'(9'd256 - mid_q[K_ARR].hr) * SS_W'(9'd256 - mid_q[K_ARR].wr);
    priority if (mid_q[K_ARR].degen) begin
      late_d.reason = RSN_DEGEN;
    end else if (mid_q[K_ARR].ad >= cfg_i.max_angle_diff) begin
      late_d.reason = RSN_ANGLE;
    end else if (mid_q[K_ARR].hr > cfg_i.max_height_diff_ratio ||
                 mid_q[K_ARR].wr > cfg_i.max_width_diff_ratio) begin
      late_d.reason = RSN_SIZE;
    end else if (mid_q[K_ARR].vfail) begin
      late_d.reason = RSN_VERT;
    end else if (ar_q < LEN_W'(cfg_i.min_aspect_ratio) ||
                 ar_q > LEN_W'(cfg_i.max_aspect_ratio)) begin
      late_d.reason = RSN_ASPECT;
    end else begin
      late_d.reason = RSN_PASS;
    end
    sr_dvs = SR_BASE + SR_D_W'(absdiff16(ar_q, LEN_W'(cfg_i.ideal_aspect_ratio)));
    sa_dvs = SA_BASE + mid_q[K_ARR].ad;
  end

  lbps_div #(.NW(SC_N_W), .DW(SR_D_W), .QW(SC_Q_W)) u_div_sr (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (SR_NUM),
    .divisor_i  (sr_dvs),
    .quotient_o (sr)
  );

  lbps_div #(.NW(SC_N_W), .DW(SA_D_W), .QW(SC_Q_W)) u_div_sa (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (SA_NUM),
    .divisor_i  (sa_dvs),
    .quotient_o (sa)
  );

  always_comb begin
    sum_d = W_SIZE * SUM_W'(late_q[K_SC].ss) + W_RATIO * SUM_W'(sr) +
            W_ANGLE * SUM_W'(sa);
    // divide by ten: multiply by 2^23/10 rounded up, then shift
    prod_d = PROD_W'(sum_q) * PROD_W'(RECIP_10);
    q10    = prod_q[PROD_W-1:RECIP_SH];

    res_d.pair_ok      = (late_q[K_PROD].reason == RSN_PASS);
    res_d.reason       = late_q[K_PROD].reason;
    res_d.left_idx     = late_q[K_PROD].left_idx;
    res_d.right_idx    = late_q[K_PROD].right_idx;
    res_d.aspect_ratio = late_q[K_PROD].ar;
    res_d.angle_diff   = late_q[K_PROD].ad;
    if (late_q[K_PROD].reason != RSN_PASS) begin
      res_d.confidence = '0;
    end else if (|q10[Q10_W-1:LEN_W]) begin
      res_d.confidence = '1;
    end else begin
      res_d.confidence = q10[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[K_OUT-1:1], head_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[K_B0] <= tag_d;
      for (int k = K_SQ; k > K_B0; k--) begin
        tag_q[k] <= tag_q[k-1];
      end
      d2_q <= d2_d;
      mid_q[K_SQ+1] <= mid_d;
      for (int k = K_ARR; k > K_SQ + 1; k--) begin
        mid_q[k] <= mid_q[k-1];
      end
      ar_q <= ar_d;
      late_q[K_ARR+1] <= late_d;
      for (int k = K_PROD; k > K_ARR + 1; k--) begin
        late_q[k] <= late_q[k-1];
      end
      sum_q  <= sum_d;
      prod_q <= prod_d;
      res_q  <= res_d;
    end
  end

  assign valid_o = v_q[K_OUT];
  assign res_o   = res_q;

  `LBPS_ASSERT_IMPL(a_reject_has_no_conf, valid_o && res_o.reason != RSN_PASS, res_o.confidence == '0)
  `LBPS_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(v_q))

endmodule

### rtl/core/light_bar_pair_scorer.sv
// Top level of the light bar pair scorer: ports, config registers, front and back.
//
// Usage:
//   s_axis carries one candidate pair per word (two bars: angle, width, height,
//   center, plus their list indices); m_axis returns one result word per pair:
//   pass flag, reject reason, left/right index, confidence, aspect ratio and
//   folded angle difference. The cfg channel writes the seven thresholds by
//   index and is always ready; write it only while no pair is in flight.
//   Throughput is one pair per cycle while m_axis is not stalled. The pipeline
//   length is set by the square root (one bit per stage) feeding the
//   aspect-ratio divider and the ratio-score divider, each producing one
//   quotient bit per stage.
//   A stalled m_axis freezes the whole arithmetic pipeline; a two-entry queue
//   after the input stage absorbs words in flight, then s_axis_tready drops.
//   Reset empties the pipeline and loads the default thresholds.
module light_bar_pair_scorer import lbps_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // angle_a, width_a, height_a, center_x_a, center_y_a, angle_b, width_b,
  // height_b, center_x_b, center_y_b, index_a, index_b
  input  logic [167:0]          s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // pair_ok, reject_reason, left_index, right_index, confidence,
  // aspect_ratio, angle_diff, 3 zero bits
  output logic [63:0]           m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  pair_t pair;
  logic  fr_valid, fr_ready;
  item_t fr_item, head;
  logic  head_valid, pop;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_ANGLE:    cfg_d.max_angle_diff         = cfg_data_i[12:0];
        CFG_MAX_HDIFF:    cfg_d.max_height_diff_ratio  = cfg_data_i[8:0];
        CFG_MAX_WDIFF:    cfg_d.max_width_diff_ratio   = cfg_data_i[8:0];
        CFG_VERT_FACTOR:  cfg_d.vertical_offset_factor = cfg_data_i[11:0];
        CFG_MIN_ASPECT:   cfg_d.min_aspect_ratio       = cfg_data_i[11:0];
        CFG_MAX_ASPECT:   cfg_d.max_aspect_ratio       = cfg_data_i[11:0];
        CFG_IDEAL_ASPECT: cfg_d.ideal_aspect_ratio     = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    pair.angle_a    = s_axis_tdata_i[13:0];
    pair.width_a    = s_axis_tdata_i[29:14];
    pair.height_a   = s_axis_tdata_i[45:30];
    pair.center_x_a = s_axis_tdata_i[61:46];
    pair.center_y_a = s_axis_tdata_i[77:62];
    pair.angle_b    = s_axis_tdata_i[91:78];
    pair.width_b    = s_axis_tdata_i[107:92];
    pair.height_b   = s_axis_tdata_i[123:108];
    pair.center_x_b = s_axis_tdata_i[139:124];
    pair.center_y_b = s_axis_tdata_i[155:140];
    pair.index_a    = s_axis_tdata_i[161:156];
    pair.index_b    = s_axis_tdata_i[167:162];
  end

  lbps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .pair_i  (pair),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .item_o  (fr_item)
  );

  lbps_fifo #(.W($bits(item_t)), .DEPTH(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid && fr_ready),
    .data_i  (fr_item),
    .ready_o (fr_ready),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  lbps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tdata_o = {3'b000, res.angle_diff, res.aspect_ratio, res.confidence,
                           res.right_idx, res.left_idx, res.reason, res.pair_ok};

endmodule

### test/lbps_checker.sv
// Scoreboard for the light bar pair scorer: predicts each pair's verdict and compares results.
`timescale 1ns / 100ps

module lbps_checker import lbps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [167:0]          s_axis_tdata_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [63:0]           m_axis_tdata_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct {
    logic             ok;
    reason_e          reason;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
    logic [15:0]      conf;
    logic [15:0]      ar;
    logic [AD_W-1:0]  ad;
  } verdict_t;

  cfg_t     thr;
  verdict_t verdict_q[$];
  int       fails;

  assign fail_count_o = fails;
  assign pending_o    = verdict_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned adiff(input longint unsigned a, input longint unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic verdict_t score_pair(input logic [167:0] w);
    verdict_t v;
    longint unsigned aa, wa, ha, xa, ya, ab, wb, hb, xb, yb;
    longint unsigned ad, mh, mw, hr, wr, ar, dx, dy, ss, sr, sa, c;
    aa = w[13:0];    wa = w[29:14];   ha = w[45:30];  xa = w[61:46];  ya = w[77:62];
    ab = w[91:78];   wb = w[107:92];  hb = w[123:108]; xb = w[139:124]; yb = w[155:140];
    hr = 0; wr = 0; ar = 0;
    v.reason = RSN_PASS;
    v.conf = '0;
    dx = adiff(xa, xb);
    dy = adiff(ya, yb);
    if (aa > ANG_HALF) aa = ANG_HALF;
    if (ab > ANG_HALF) ab = ANG_HALF;
    ad = adiff(aa, ab);
    if (ad > ANG_QUARTER) ad = ANG_HALF - ad;
    mh = ha > hb ? ha : hb;
    mw = wa > wb ? wa : wb;
    if (mh != 0) begin
      c = int_sqrt((dx * dx + dy * dy) << 16) / mh;
      ar = c > 65535 ? 65535 : c;
    end
    if (mh == 0 || mw == 0) begin
      v.reason = RSN_DEGEN;
    end else begin
      hr = (adiff(ha, hb) << 8) / mh;
      wr = (adiff(wa, wb) << 8) / mw;
      if (ad >= thr.max_angle_diff) v.reason = RSN_ANGLE;
      else if (hr > thr.max_height_diff_ratio || wr > thr.max_width_diff_ratio)
        v.reason = RSN_SIZE;
      else if (dy * 256 > mh * thr.vertical_offset_factor) v.reason = RSN_VERT;
      else if (ar < thr.min_aspect_ratio || ar > thr.max_aspect_ratio)
        v.reason = RSN_ASPECT;
    end
    if (v.reason == RSN_PASS) begin
      ss = (256 - hr) * (256 - wr);
      sr = (64'd1 << 24) / (256 + adiff(ar, thr.ideal_aspect_ratio));
      sa = (64'd65536 * 320) / (320 + ad);
      c = (3 * ss + 4 * sr + 3 * sa) / 10;
      v.conf = c > 65535 ? 16'hFFFF : c[15:0];
    end
    v.ok        = (v.reason == RSN_PASS);
    v.left_idx  = xa < xb ? w[161:156] : w[167:162];
    v.right_idx = xa < xb ? w[167:162] : w[161:156];
    v.ar        = ar[15:0];
    v.ad        = ad[AD_W-1:0];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t e;
    if (!rst_ni) begin
      thr = CFG_RESET;
      verdict_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_ANGLE:    thr.max_angle_diff         = cfg_data_i[12:0];
          CFG_MAX_HDIFF:    thr.max_height_diff_ratio  = cfg_data_i[8:0];
          CFG_MAX_WDIFF:    thr.max_width_diff_ratio   = cfg_data_i[8:0];
          CFG_VERT_FACTOR:  thr.vertical_offset_factor = cfg_data_i[11:0];
          CFG_MIN_ASPECT:   thr.min_aspect_ratio       = cfg_data_i[11:0];
          CFG_MAX_ASPECT:   thr.max_aspect_ratio       = cfg_data_i[11:0];
          CFG_IDEAL_ASPECT: thr.ideal_aspect_ratio     = cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result word with no pair outstanding: %h", m_axis_tdata_i);
          fails++;
        end else begin
          e = verdict_q.pop_front();
          if (m_axis_tdata_i[0] !== e.ok) begin
            $error("pair_ok expected %0d got %0d", e.ok, m_axis_tdata_i[0]); fails++;
          end
          if (m_axis_tdata_i[3:1] !== e.reason) begin
            $error("reject_reason expected %0d got %0d", e.reason, m_axis_tdata_i[3:1]);
            fails++;
          end
          if (m_axis_tdata_i[9:4] !== e.left_idx) begin
            $error("left_index expected %0d got %0d", e.left_idx, m_axis_tdata_i[9:4]);
            fails++;
          end
          if (m_axis_tdata_i[15:10] !== e.right_idx) begin
            $error("right_index expected %0d got %0d", e.right_idx, m_axis_tdata_i[15:10]);
            fails++;
          end
          if (m_axis_tdata_i[31:16] !== e.conf) begin
            $error("confidence expected %0d got %0d", e.conf, m_axis_tdata_i[31:16]);
            fails++;
          end
          if (m_axis_tdata_i[47:32] !== e.ar) begin
            $error("aspect_ratio expected %0d got %0d", e.ar, m_axis_tdata_i[47:32]);
            fails++;
          end
          if (m_axis_tdata_i[60:48] !== e.ad) begin
            $error("angle_diff expected %0d got %0d", e.ad, m_axis_tdata_i[60:48]);
            fails++;
          end
        end
      end
      // predict after the config update of this edge; writes only happen while idle
      if (s_axis_tvalid_i && s_axis_tready_i) verdict_q = {verdict_q, score_pair(s_axis_tdata_i)};
    end
  end

endmodule

### test/tb_light_bar_pair_scorer.sv
// Testbench top for the light bar pair scorer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_light_bar_pair_scorer;
  import lbps_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [167:0]          s_data = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [63:0]           m_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, pending;
  bit                    hold_rx = 1'b0;
  int                    idle_cycles = 0;

  light_bar_pair_scorer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  lbps_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_i(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [167:0] pack_pair(
      input logic [13:0] aa, input logic [15:0] wa, ha, xa, ya,
      input logic [13:0] ab, input logic [15:0] wb, hb, xb, yb,
      input logic [5:0] ia, ib);
    return {ib, ia, yb, xb, hb, wb, ab, ya, xa, ha, wa, aa};
  endfunction

  // plausible pair: similar bars side by side, random content within reach of every test
  function automatic logic [167:0] plausible_pair();
    int h, w, dx, a, cx, cy;
    h  = $urandom_range(8, 6000);
    w  = $urandom_range(1, h / 2 + 1);
    dx = h * $urandom_range(0, 700) / 100;
    if (dx > 60000) dx = 60000;
    a  = $urandom_range(0, 11520);
    cx = $urandom_range(0, 65535 - dx);
    cy = $urandom_range(h, 65535 - h);
    return pack_pair(14'(a), 16'(w), 16'(h), 16'(cx), 16'(cy),
                     14'((a + $urandom_range(0, 1600) + 11520 - 800) % 11520),
                     16'(w + $urandom_range(0, w / 2)), 16'(h - $urandom_range(0, h / 3)),
                     16'(cx + dx), 16'(cy + $urandom_range(0, h / 3) - h / 6),
                     6'($urandom), 6'($urandom));
  endfunction

  task automatic send_pair(input logic [167:0] d);
    s_valid <= 1'b1;
    s_data  <= d;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic send_burst(input int n, input int max_gap);
    int left, burst, gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && left > 0; k++, left--)
        send_pair(($urandom_range(0, 3) == 0)
                  ? 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom})
                  : plausible_pair());
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic load_thresholds(input logic [12:0] ang, input logic [12:0] hd, wd, vf,
                                 input logic [12:0] amin, amax, aid);
    s_valid <= 1'b0;
    drain();
    write_reg(CFG_MAX_ANGLE, ang);
    write_reg(CFG_MAX_HDIFF, hd);
    write_reg(CFG_MAX_WDIFF, wd);
    write_reg(CFG_VERT_FACTOR, vf);
    write_reg(CFG_MIN_ASPECT, amin);
    write_reg(CFG_MAX_ASPECT, amax);
    write_reg(CFG_IDEAL_ASPECT, aid);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stall runs, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_rx) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        m_ready <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: degenerate, extremes, clamped angles, ties, each reject reason
    send_pair('0);
    send_pair('1);
    send_pair(pack_pair(0, 0, 100, 0, 0, 0, 0, 100, 50, 0, 1, 2));
    send_pair(pack_pair(0, 100, 0, 0, 0, 0, 50, 0, 50, 0, 3, 4));
    send_pair(pack_pair(16383, 40, 160, 1000, 5000, 0, 40, 160, 1384, 5000, 5, 6));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 11520, 40, 160, 1384, 5000, 7, 8));
    send_pair(pack_pair(100, 40, 160, 1384, 5000, 11500, 40, 160, 1000, 5000, 9, 10));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 5760, 40, 160, 1384, 5000, 11, 12));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 1279, 40, 160, 1384, 5000, 13, 14));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 1280, 40, 160, 1384, 5000, 15, 16));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 0, 40, 60, 1384, 5000, 17, 18));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 0, 4, 160, 1384, 5000, 19, 20));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 0, 40, 160, 1384, 5300, 21, 22));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 0, 40, 160, 1100, 5000, 23, 24));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 0, 40, 160, 3000, 5000, 25, 26));
    send_pair(pack_pair(0, 40, 160, 1000, 5000, 0, 40, 160, 1000, 5000, 33, 33));
    send_pair(pack_pair(0, 1, 1, 0, 0, 0, 1, 1, 65535, 65535, 63, 0));
    send_pair(pack_pair(0, 65535, 65535, 0, 0, 0, 65535, 65535, 65535, 0, 0, 63));
    send_pair(pack_pair(2000, 400, 1600, 100, 100, 0, 400, 1600, 3940, 100, 42, 21));

    send_burst(200, 20);
    // long receiver hold-off while the sender keeps offering
    hold_rx = 1'b1;
    send_burst(150, 0);
    load_thresholds(0, 0, 0, 0, 0, 0, 0);
    send_burst(120, 10);
    load_thresholds(8191, 511, 511, 4095, 4095, 4095, 4095);
    send_burst(120, 10);
    load_thresholds(5760, 256, 256, 2048, 0, 4095, 0);
    send_burst(150, 6);
    load_thresholds(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom),
                    13'($urandom_range(0, 600)), 13'($urandom_range(600, 4095)),
                    13'($urandom));
    send_burst(150, 8);
    load_thresholds(1280, 128, 205, 307, 256, 1536, 614);
    send_burst(200, 4);

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
